@@ src/hkv_pkg.sv @@
// shared types and codes for the hashed key-value table
`default_nettype none
package hkv_pkg;

   localparam int MAX_KEY_BYTES = 16;
   localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;

   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   localparam logic [2:0] ST_FOUND     = 3'd0;
   localparam logic [2:0] ST_NOT_FOUND = 3'd1;
   localparam logic [2:0] ST_INSERTED  = 3'd2;
   localparam logic [2:0] ST_UPDATED   = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   typedef struct packed {
      logic        func;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [4:0]  key_len;
      logic [31:0] new_value;
   } hkv_item_type;

   typedef struct packed {
      logic        valid;
      logic [4:0]  key_len;
      logic [63:0] key_high;
      logic [63:0] key_low;
      logic [31:0] value;
   } hkv_slot_type;

   // fnv prime is 2^40 + 0x1b3, so the product is a handful of shifted adds
   function automatic logic [63:0] fnv_mult(input logic [63:0] x);
      fnv_mult = (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
   endfunction

endpackage
`default_nettype wire

@@ src/hashed_key_value_table.sv @@
// top level: fnv-1a hashed key-value table with linear probing
// path: the front hashes the key one byte per hash round, reduces the hash to a home
//   slot and pushes it into the queue; the back end then reads and checks each probed slot
// overlap: the front hashes the next request while the back end probes
// reset: synchronous; afterwards a clearing pass over every slot empties the
//   slot memory and the back end takes no request until it is done
`default_nettype none
module hashed_key_value_table
   import hkv_pkg::*;
#(
   parameter int CAPACITY = 256
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,  // key_low, key_high, key_len, new_value, zero pad
   input  wire logic [0:0]   req_tuser,  // func
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [47:0]       rsp_tdata,  // found_value, entries_used, zero pad
   output logic [2:0]        rsp_tuser   // status
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int Q_W   = $bits(hkv_item_type) + IDX_W;

   hkv_item_type     req_item, fr_item, bk_item;
   logic [IDX_W-1:0] fr_home, bk_home;
   logic             fr_valid, fr_ready, bk_valid, bk_ready;
   logic [31:0]      rsp_value;
   logic [8:0]       rsp_count;

   always_comb begin
      req_item.func      = req_tuser[0];
      req_item.key_low   = req_tdata[63:0];
      req_item.key_high  = req_tdata[127:64];
      req_item.key_len   = req_tdata[132:128];
      req_item.new_value = req_tdata[164:133];
   end

   hkv_front #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (req_item),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .out_item  (fr_item),
      .out_home  (fr_home)
   );

   hkv_queue #(.WIDTH(Q_W)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .in_data   ({fr_item, fr_home}),
      .out_valid (bk_valid),
      .out_ready (bk_ready),
      .out_data  ({bk_item, bk_home})
   );

   hkv_back #(.CAPACITY(CAPACITY), .IDX_W(IDX_W)) u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (bk_valid),
      .in_ready   (bk_ready),
      .in_item    (bk_item),
      .in_home    (bk_home),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_status (rsp_tuser),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_count)
   );

   assign rsp_tdata = {7'd0, rsp_count, rsp_value};

endmodule
`default_nettype wire

@@ src/hkv_front.sv @@
// front end: takes requests, masks the key, hashes it and reduces to a home slot
`default_nettype none
module hkv_front
   import hkv_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int IDX_W    = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hkv_item_type     in_item,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output hkv_item_type          out_item,
   output logic [IDX_W-1:0]      out_home
);

   typedef enum logic [3:0] {
      F_IDLE = 4'b0001,
      F_HASH = 4'b0010,
      F_MOD  = 4'b0100,
      F_PUSH = 4'b1000
   } front_state_type;

   localparam logic [IDX_W+1:0] CAP_EXT = (IDX_W+2)'(CAPACITY);
   localparam logic [4:0] MAX_LEN = 5'(MAX_KEY_BYTES);

   front_state_type state_ff, state_in;
   hkv_item_type    item_ff, item_in;
   logic [63:0]     hash_ff, hash_in;
   logic [3:0]      byte_ff, byte_in;
   logic [2:0]      mod_cnt_ff, mod_cnt_in;
   logic [IDX_W:0]  rem_ff, rem_in;

   logic [4:0]   len_sat;
   logic [127:0] key_raw, key_masked;
   logic [7:0]   cur_byte;
   logic [IDX_W+1:0] trial;

   function automatic logic [7:0] key_byte(input logic [3:0] i);
      logic [127:0] k;
      k = {item_ff.key_high, item_ff.key_low};
      key_byte = k[{i, 3'b000} +: 8];
   endfunction

   assign in_ready  = (state_ff == F_IDLE);
   assign out_valid = (state_ff == F_PUSH);
   assign out_item  = item_ff;
   assign out_home  = rem_ff[IDX_W-1:0];
   assign cur_byte  = key_byte(byte_ff);

   always_comb begin
      len_sat = (in_item.key_len > MAX_LEN) ? MAX_LEN : in_item.key_len;
      key_raw = {in_item.key_high, in_item.key_low};
      for (int i = 0; i < 16; i++) begin
         key_masked[i*8 +: 8] = (5'(i) < len_sat) ? key_raw[i*8 +: 8] : 8'h00;
      end
   end

   always_comb begin
      state_in   = state_ff;
      item_in    = item_ff;
      hash_in    = hash_ff;
      byte_in    = byte_ff;
      mod_cnt_in = mod_cnt_ff;
      rem_in     = rem_ff;
      trial      = '0;
      case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               item_in.func      = in_item.func;
               item_in.key_low   = key_masked[63:0];
               item_in.key_high  = key_masked[127:64];
               item_in.key_len   = len_sat;
               item_in.new_value = in_item.new_value;
               hash_in    = FNV_BASIS;
               byte_in    = '0;
               mod_cnt_in = '0;
               rem_in     = '0;
               state_in   = (len_sat == 5'd0) ? F_MOD : F_HASH;
            end
         end
         F_HASH: begin
            hash_in = fnv_mult(hash_ff ^ {56'd0, cur_byte});
            byte_in = byte_ff + 4'd1;
            if (({1'b0, byte_ff} + 5'd1) == item_ff.key_len) begin
               state_in = F_MOD;
            end
         end
         F_MOD: begin
            // remainder by capacity, eight hash bits per cycle, msb first
            for (int k = 0; k < 8; k++) begin
               trial = {rem_in, hash_ff[63-k]};
               if (trial >= CAP_EXT) begin
                  trial = trial - CAP_EXT;
               end
               rem_in = trial[IDX_W:0];
            end
            hash_in    = hash_ff << 8;
            mod_cnt_in = mod_cnt_ff + 3'd1;
            if (mod_cnt_ff == 3'd7) begin
               state_in = F_PUSH;
            end
         end
         F_PUSH: begin
            if (out_ready) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff    <= item_in;
      hash_ff    <= hash_in;
      byte_ff    <= byte_in;
      mod_cnt_ff <= mod_cnt_in;
      rem_ff     <= rem_in;
   end

endmodule
`default_nettype wire

@@ src/hkv_queue.sv @@
// two-entry queue between front and back ends
`default_nettype none
module hkv_queue #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic [WIDTH-1:0]      out_data
);

   logic [WIDTH-1:0] data_ff [2];
   logic [1:0] count_ff, count_in;
   logic       rd_ptr_ff, wr_ptr_ff;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
      if (push) begin
         data_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule
`default_nettype wire

@@ src/hkv_back.sv @@
// back end: slot memory, linear probe, insert/update and response register
`default_nettype none
module hkv_back
   import hkv_pkg::*;
#(
   parameter int CAPACITY = 256,
   parameter int IDX_W    = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hkv_item_type     in_item,
   input  wire logic [IDX_W-1:0] in_home,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [31:0]           rsp_value,
   output logic [8:0]            rsp_count
);

   typedef enum logic [3:0] {
      B_CLEAR = 4'b0001,
      B_IDLE  = 4'b0010,
      B_READ  = 4'b0100,
      B_CHECK = 4'b1000
   } back_state_type;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [IDX_W+1:0] CAP_EXT  = (IDX_W+2)'(CAPACITY);

   hkv_slot_type mem [CAPACITY];

   back_state_type   state_ff, state_in;
   hkv_item_type     item_ff;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [IDX_W-1:0] clr_ff;
   logic [IDX_W-1:0] count_ff, count_in;
   hkv_slot_type     rd_ff;
   logic             rsp_valid_ff;
   logic [2:0]       rsp_status_ff;
   logic [31:0]      rsp_value_ff;
   logic [8:0]       rsp_count_ff;

   logic         hit, done, out_free, table_full, load_rsp;
   logic         wr_en;
   logic [IDX_W-1:0] wr_addr;
   hkv_slot_type wr_data;
   logic [2:0]   status_in;
   logic [31:0]  value_in;

   assign in_ready   = (state_ff == B_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign hit = rd_ff.valid && (rd_ff.key_len == item_ff.key_len) &&
                (rd_ff.key_low == item_ff.key_low) && (rd_ff.key_high == item_ff.key_high);
   assign done       = !rd_ff.valid || hit;
   assign table_full = ({1'b0, count_ff, 1'b0} >= CAP_EXT);

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      count_in  = count_ff;
      wr_en     = 1'b0;
      wr_addr   = idx_ff;
      wr_data   = '0;
      status_in = ST_NOT_FOUND;
      value_in  = '0;
      load_rsp  = 1'b0;
      case (state_ff)
         B_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            if (clr_ff == LAST_IDX) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (in_valid) begin
               idx_in   = in_home;
               state_in = B_READ;
            end
         end
         B_READ: begin
            state_in = B_CHECK;
         end
         B_CHECK: begin
            if (!done) begin
               idx_in   = (idx_ff == LAST_IDX) ? '0 : idx_ff + 1'b1;
               state_in = B_READ;
            end else if (out_free) begin
               load_rsp = 1'b1;
               state_in = B_IDLE;
               wr_data.valid    = 1'b1;
               wr_data.key_len  = item_ff.key_len;
               wr_data.key_low  = item_ff.key_low;
               wr_data.key_high = item_ff.key_high;
               wr_data.value    = item_ff.new_value;
               if (item_ff.func == FUNC_LOOKUP) begin
                  status_in = hit ? ST_FOUND : ST_NOT_FOUND;
                  value_in  = hit ? rd_ff.value : '0;
               end else if (hit) begin
                  status_in = ST_UPDATED;
                  wr_en     = 1'b1;
               end else if (table_full) begin
                  status_in = ST_FULL;
               end else begin
                  status_in = ST_INSERTED;
                  wr_en     = 1'b1;
                  count_in  = count_ff + 1'b1;
               end
            end
         end
         default: state_in = B_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (state_ff == B_READ) begin
         rd_ff <= mem[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         if (state_ff == B_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (state_ff == B_IDLE && in_valid) begin
         item_ff <= in_item;
      end
      idx_ff <= idx_in;
      if (load_rsp) begin
         rsp_status_ff <= status_in;
         rsp_value_ff  <= value_in;
         rsp_count_ff  <= 9'(count_in);
      end
   end

endmodule
`default_nettype wire

@@ src/hkv_checker.sv @@
// port-level checks for the hashed key-value table
`default_nettype none
module hkv_checker
   import hkv_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_tvalid,
   input wire logic         req_tready,
   input wire logic [167:0] req_tdata,
   input wire logic [0:0]   req_tuser,
   input wire logic         rsp_tvalid,
   input wire logic         rsp_tready,
   input wire logic [47:0]  rsp_tdata,
   input wire logic [2:0]   rsp_tuser
);

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser == ST_FOUND || rsp_tuser == ST_NOT_FOUND ||
                      rsp_tuser == ST_INSERTED || rsp_tuser == ST_UPDATED ||
                      rsp_tuser == ST_FULL))
      else $error("bad status code");

   a_value_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != ST_FOUND |-> rsp_tdata[31:0] == 32'd0)
      else $error("value not zero without a hit");

   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == ST_INSERTED |-> rsp_tdata[40:32] != 9'd0)
      else $error("insert left entry count at zero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !req_tready |=> req_tvalid && $stable(req_tdata) && $stable(req_tuser))
      else $error("stalled request changed");

endmodule

bind hashed_key_value_table hkv_checker u_hkv_checker (.*);
`default_nettype wire
